@@ rtl/tbw_pkg.sv @@
// ----------------------------------------------------------------------------
// Barycentric weights package
// Widths, item types and the saturation helper shared by the weights unit.
// ----------------------------------------------------------------------------
package tbw_pkg;

  localparam int unsigned COORD_W          = 32;
  localparam int unsigned WEIGHT_W         = 32;
  localparam int unsigned WEIGHT_FRAC_BITS = 24;

  // Exact widths of the intermediate values.
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned DOT_W   = PROD_W + 2;
  localparam int unsigned HALF_W  = DOT_W / 2;
  localparam int unsigned MID_W   = 2 * HALF_W + 2;
  localparam int unsigned MUL_W   = 2 * DOT_W;
  localparam int unsigned GRAM_W  = MUL_W + 1;
  localparam int unsigned NUM_W   = GRAM_W + WEIGHT_FRAC_BITS;
  localparam int unsigned RQ_W    = GRAM_W + NUM_W;
  localparam int unsigned QS_W    = NUM_W + 1;
  localparam int unsigned QA_W    = NUM_W + 3;

  localparam int unsigned NUM_DOTS     = 5;
  localparam int unsigned NUM_MULS     = 6;
  localparam int unsigned MUL_LAT      = 3;
  localparam int unsigned FRONT_STAGES = 3 + MUL_LAT + 1;
  localparam int unsigned BACK_STAGES  = NUM_W + 3;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  // Dot product indexes.
  localparam int unsigned DOT_00 = 0;
  localparam int unsigned DOT_01 = 1;
  localparam int unsigned DOT_11 = 2;
  localparam int unsigned DOT_20 = 3;
  localparam int unsigned DOT_21 = 4;

  // Gram products: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
  localparam int unsigned MUL_A [NUM_MULS] = '{DOT_00, DOT_01, DOT_11, DOT_01, DOT_00, DOT_01};
  localparam int unsigned MUL_B [NUM_MULS] = '{DOT_11, DOT_01, DOT_20, DOT_21, DOT_21, DOT_20};

  localparam logic [QA_W-1:0] WEIGHT_ONE = QA_W'(1) << WEIGHT_FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
    logic signed [COORD_W-1:0] p_x;
    logic signed [COORD_W-1:0] p_y;
    logic signed [COORD_W-1:0] p_z;
  } in_item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_c;
    logic signed [WEIGHT_W-1:0] weight_b;
    logic signed [WEIGHT_W-1:0] weight_a;
    logic                       degenerate;
    logic                       saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [GRAM_W-1:0] den;
    logic signed [GRAM_W-1:0] nu;
    logic signed [GRAM_W-1:0] nv;
    logic                     degenerate;
  } gram_t;

  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic degenerate;
  } side_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] value;
    logic                       clip;
  } sat_t;

  function automatic sat_t sat_weight(input logic [QA_W-1:0] x);
    sat_t r;
    logic [QA_W-WEIGHT_W:0] top;
    top = x[QA_W-1:WEIGHT_W-1];
    if ((&top) || !(|top)) begin
      r.value = x[WEIGHT_W-1:0];
      r.clip  = 1'b0;
    end else begin
      r.value = x[QA_W-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
      r.clip  = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/tbw_mul.sv @@
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Splits both operands in halves; partial products, then middle sum, then
// the final add, one register after each.
// ----------------------------------------------------------------------------
module tbw_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [tbw_pkg::DOT_W-1:0]   a_i,
  input  logic signed [tbw_pkg::DOT_W-1:0]   b_i,
  output logic signed [tbw_pkg::MUL_W-1:0]   p_o
);

  logic signed [tbw_pkg::HALF_W-1:0]   ah, bh;
  logic        [tbw_pkg::HALF_W-1:0]   al, bl;
  logic signed [tbw_pkg::HALF_W:0]     alx, blx;

  logic signed [2*tbw_pkg::HALF_W-1:0] hh_q;
  logic signed [2*tbw_pkg::HALF_W:0]   hl_q, lh_q;
  logic        [2*tbw_pkg::HALF_W-1:0] ll_q;
  logic signed [tbw_pkg::MID_W-1:0]    mid_q;
  logic signed [tbw_pkg::MUL_W-1:0]    cat_q;
  logic signed [tbw_pkg::MUL_W-1:0]    p_q;

  assign ah  = a_i[tbw_pkg::DOT_W-1:tbw_pkg::HALF_W];
  assign bh  = b_i[tbw_pkg::DOT_W-1:tbw_pkg::HALF_W];
  assign al  = a_i[tbw_pkg::HALF_W-1:0];
  assign bl  = b_i[tbw_pkg::HALF_W-1:0];
  assign alx = {1'b0, al};
  assign blx = {1'b0, bl};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q  <= ah * bh;
      hl_q  <= ah * blx;
      lh_q  <= alx * bh;
      ll_q  <= al * bl;
      mid_q <= tbw_pkg::MID_W'(hl_q) + tbw_pkg::MID_W'(lh_q);
      cat_q <= {hh_q, ll_q};
      p_q   <= cat_q + (tbw_pkg::MUL_W'(mid_q) <<< tbw_pkg::HALF_W);
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/tbw_front.sv @@
// ----------------------------------------------------------------------------
// Weights front end
// Takes each item, forms the edge vectors, the five dot products and the
// Gram determinant and numerators, and marks degenerate triangles.
// ----------------------------------------------------------------------------
module tbw_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tbw_pkg::in_item_t  in_item_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output tbw_pkg::gram_t     push_item_o
);

  logic [tbw_pkg::FRONT_STAGES-1:0] v_q;
  logic                             en;

  logic signed [tbw_pkg::COORD_W-1:0] a_c [3], b_c [3], c_c [3], p_c [3];
  logic signed [tbw_pkg::DIFF_W-1:0]  e0_q [3], e1_q [3], qv_q [3];
  logic signed [tbw_pkg::DIFF_W-1:0]  op_x [tbw_pkg::NUM_DOTS][3];
  logic signed [tbw_pkg::DIFF_W-1:0]  op_y [tbw_pkg::NUM_DOTS][3];
  logic signed [tbw_pkg::PROD_W-1:0]  pr_q [tbw_pkg::NUM_DOTS][3];
  logic signed [tbw_pkg::DOT_W-1:0]   dot_q [tbw_pkg::NUM_DOTS];
  logic signed [tbw_pkg::MUL_W-1:0]   mp [tbw_pkg::NUM_MULS];
  logic signed [tbw_pkg::GRAM_W-1:0]  den_q, nu_q, nv_q;

  assign en           = ~v_q[tbw_pkg::FRONT_STAGES-1] | push_ready_i;
  assign in_ready_o   = en;
  assign push_valid_o = v_q[tbw_pkg::FRONT_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[tbw_pkg::FRONT_STAGES-2:0], in_valid_i};
    end
  end

  assign a_c[0] = in_item_i.a_x;
  assign a_c[1] = in_item_i.a_y;
  assign a_c[2] = in_item_i.a_z;
  assign b_c[0] = in_item_i.b_x;
  assign b_c[1] = in_item_i.b_y;
  assign b_c[2] = in_item_i.b_z;
  assign c_c[0] = in_item_i.c_x;
  assign c_c[1] = in_item_i.c_y;
  assign c_c[2] = in_item_i.c_z;
  assign p_c[0] = in_item_i.p_x;
  assign p_c[1] = in_item_i.p_y;
  assign p_c[2] = in_item_i.p_z;

  // Operand pairs of the five dot products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      op_x[tbw_pkg::DOT_00][k] = e0_q[k];
      op_y[tbw_pkg::DOT_00][k] = e0_q[k];
      op_x[tbw_pkg::DOT_01][k] = e0_q[k];
      op_y[tbw_pkg::DOT_01][k] = e1_q[k];
      op_x[tbw_pkg::DOT_11][k] = e1_q[k];
      op_y[tbw_pkg::DOT_11][k] = e1_q[k];
      op_x[tbw_pkg::DOT_20][k] = qv_q[k];
      op_y[tbw_pkg::DOT_20][k] = e0_q[k];
      op_x[tbw_pkg::DOT_21][k] = qv_q[k];
      op_y[tbw_pkg::DOT_21][k] = e1_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e0_q[k] <= tbw_pkg::DIFF_W'(c_c[k]) - tbw_pkg::DIFF_W'(a_c[k]);
        e1_q[k] <= tbw_pkg::DIFF_W'(b_c[k]) - tbw_pkg::DIFF_W'(a_c[k]);
        qv_q[k] <= tbw_pkg::DIFF_W'(p_c[k]) - tbw_pkg::DIFF_W'(a_c[k]);
      end
      for (int j = 0; j < tbw_pkg::NUM_DOTS; j++) begin
        for (int k = 0; k < 3; k++) begin
          pr_q[j][k] <= op_x[j][k] * op_y[j][k];
        end
        dot_q[j] <= tbw_pkg::DOT_W'(pr_q[j][0]) + tbw_pkg::DOT_W'(pr_q[j][1])
                  + tbw_pkg::DOT_W'(pr_q[j][2]);
      end
      den_q <= tbw_pkg::GRAM_W'(mp[0]) - tbw_pkg::GRAM_W'(mp[1]);
      nu_q  <= tbw_pkg::GRAM_W'(mp[2]) - tbw_pkg::GRAM_W'(mp[3]);
      nv_q  <= tbw_pkg::GRAM_W'(mp[4]) - tbw_pkg::GRAM_W'(mp[5]);
    end
  end

  for (genvar m = 0; m < tbw_pkg::NUM_MULS; m++) begin : g_mul
    tbw_mul u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (dot_q[tbw_pkg::MUL_A[m]]),
      .b_i   (dot_q[tbw_pkg::MUL_B[m]]),
      .p_o   (mp[m])
    );
  end

  assign push_item_o.den        = den_q;
  assign push_item_o.nu         = nu_q;
  assign push_item_o.nv         = nv_q;
  assign push_item_o.degenerate = (den_q == '0);

endmodule

@@ rtl/tbw_queue.sv @@
// ----------------------------------------------------------------------------
// Gram item queue
// Short first-in first-out buffer between the front end and the divider.
// ----------------------------------------------------------------------------
module tbw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tbw_pkg::gram_t  push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tbw_pkg::gram_t  pop_item_o
);

  tbw_pkg::gram_t                entry_q [tbw_pkg::QUEUE_DEPTH];
  logic [tbw_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [tbw_pkg::QPTR_W:0]      count_q;
  logic                          push, pop;

  assign push_ready_o = (count_q != (tbw_pkg::QPTR_W + 1)'(tbw_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/tbw_divider.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned quotient of the magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tbw_divider (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [tbw_pkg::NUM_W-1:0]     num_i,
  input  logic [tbw_pkg::GRAM_W-1:0]    den_i,
  output logic [tbw_pkg::NUM_W-1:0]     quo_o
);

  // Upper part holds the partial remainder, lower part the numerator bits
  // still to come and, from the bottom, the quotient bits found so far.
  logic [tbw_pkg::RQ_W-1:0]   rq_q [tbw_pkg::NUM_W];
  logic [tbw_pkg::GRAM_W-1:0] d_q  [tbw_pkg::NUM_W-1];

  for (genvar s = 0; s < tbw_pkg::NUM_W; s++) begin : g_step
    logic [tbw_pkg::RQ_W-1:0]   rq_in;
    logic [tbw_pkg::GRAM_W-1:0] d_in;
    logic [tbw_pkg::GRAM_W:0]   up;
    logic [tbw_pkg::GRAM_W+1:0] diff;
    logic                       ge;

    if (s == 0) begin : g_first
      assign rq_in = {{tbw_pkg::GRAM_W{1'b0}}, num_i};
      assign d_in  = den_i;
    end else begin : g_next
      assign rq_in = rq_q[s-1];
      assign d_in  = d_q[s-1];
    end

    always_comb begin
      up   = {rq_in[tbw_pkg::RQ_W-1 -: tbw_pkg::GRAM_W], rq_in[tbw_pkg::NUM_W-1]};
      diff = {1'b0, up} - {2'b00, d_in};
      ge   = ~diff[tbw_pkg::GRAM_W+1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rq_q[s] <= {(ge ? diff[tbw_pkg::GRAM_W-1:0] : up[tbw_pkg::GRAM_W-1:0]),
                    rq_in[tbw_pkg::NUM_W-2:0], ge};
      end
    end

    if (s < tbw_pkg::NUM_W - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          d_q[s] <= d_in;
        end
      end
    end
  end

  assign quo_o = rq_q[tbw_pkg::NUM_W-1][tbw_pkg::NUM_W-1:0];

endmodule

@@ rtl/tbw_back.sv @@
// ----------------------------------------------------------------------------
// Weights back end
// Divides both numerators by the determinant, restores the signs, forms the
// weight of A and saturates all three into the output register.
// ----------------------------------------------------------------------------
module tbw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  tbw_pkg::gram_t     pop_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tbw_pkg::out_item_t out_item_o
);

  logic [tbw_pkg::BACK_STAGES-1:0] v_q;
  logic                            en;

  logic [tbw_pkg::GRAM_W-1:0]        nu_abs, nv_abs, den_abs;
  logic [tbw_pkg::NUM_W-1:0]         num_u_q, num_v_q;
  logic [tbw_pkg::GRAM_W-1:0]        den_q;
  tbw_pkg::side_t                    side0_q;
  tbw_pkg::side_t                    side_q [tbw_pkg::NUM_W];
  logic [tbw_pkg::NUM_W-1:0]         quo_u, quo_v;
  logic signed [tbw_pkg::QS_W-1:0]   qu_q, qv_q;
  logic                              degen_q;
  logic [tbw_pkg::QA_W-1:0]          qa;
  tbw_pkg::sat_t                     su, sv, sa;
  tbw_pkg::out_item_t                out_d, out_q;

  assign en          = ~v_q[tbw_pkg::BACK_STAGES-1] | out_ready_i;
  assign pop_ready_o = en;
  assign out_valid_o = v_q[tbw_pkg::BACK_STAGES-1];
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[tbw_pkg::BACK_STAGES-2:0], pop_valid_i};
    end
  end

  always_comb begin
    nu_abs  = pop_item_i.nu[tbw_pkg::GRAM_W-1]  ? -pop_item_i.nu  : pop_item_i.nu;
    nv_abs  = pop_item_i.nv[tbw_pkg::GRAM_W-1]  ? -pop_item_i.nv  : pop_item_i.nv;
    den_abs = pop_item_i.den[tbw_pkg::GRAM_W-1] ? -pop_item_i.den : pop_item_i.den;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_u_q          <= {nu_abs, {tbw_pkg::WEIGHT_FRAC_BITS{1'b0}}};
      num_v_q          <= {nv_abs, {tbw_pkg::WEIGHT_FRAC_BITS{1'b0}}};
      den_q            <= den_abs;
      side0_q.neg_u    <= pop_item_i.nu[tbw_pkg::GRAM_W-1] ^ pop_item_i.den[tbw_pkg::GRAM_W-1];
      side0_q.neg_v    <= pop_item_i.nv[tbw_pkg::GRAM_W-1] ^ pop_item_i.den[tbw_pkg::GRAM_W-1];
      side0_q.degenerate <= pop_item_i.degenerate;
      side_q[0]        <= side0_q;
      for (int i = 1; i < tbw_pkg::NUM_W; i++) begin
        side_q[i] <= side_q[i-1];
      end
      qu_q    <= side_q[tbw_pkg::NUM_W-1].neg_u ? -$signed({1'b0, quo_u}) : $signed({1'b0, quo_u});
      qv_q    <= side_q[tbw_pkg::NUM_W-1].neg_v ? -$signed({1'b0, quo_v}) : $signed({1'b0, quo_v});
      degen_q <= side_q[tbw_pkg::NUM_W-1].degenerate;
      out_q   <= out_d;
    end
  end

  // A zero determinant leaves the dividers with a meaningless quotient,
  // which the degenerate case below overrides.
  tbw_divider u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_u_q),
    .den_i (den_q),
    .quo_o (quo_u)
  );

  tbw_divider u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_v_q),
    .den_i (den_q),
    .quo_o (quo_v)
  );

  always_comb begin
    qa  = tbw_pkg::WEIGHT_ONE - tbw_pkg::QA_W'(qu_q) - tbw_pkg::QA_W'(qv_q);
    su  = tbw_pkg::sat_weight(tbw_pkg::QA_W'(qu_q));
    sv  = tbw_pkg::sat_weight(tbw_pkg::QA_W'(qv_q));
    sa  = tbw_pkg::sat_weight(qa);
    if (degen_q) begin
      out_d.weight_c   = '0;
      out_d.weight_b   = '0;
      out_d.weight_a   = '0;
      out_d.degenerate = 1'b1;
      out_d.saturated  = 1'b0;
    end else begin
      out_d.weight_c   = su.value;
      out_d.weight_b   = sv.value;
      out_d.weight_a   = sa.value;
      out_d.degenerate = 1'b0;
      out_d.saturated  = su.clip | sv.clip | sa.clip;
    end
  end

endmodule

@@ rtl/triangle_barycentric_weights_unit.sv @@
// ----------------------------------------------------------------------------
// Triangle barycentric weights unit
// Weights of a query point against a triangle by the Gram system method.
//
//   Channel  Direction  Handshake                     Payload
//   in       input      in_valid_i / in_ready_o       in_item_i  (tbw_pkg::in_item_t)
//   out      output     out_valid_o / out_ready_i     out_item_o (tbw_pkg::out_item_t)
//
// One item is taken every cycle and one result leaves every cycle while neither end stalls.
// The front end registers the differences, the dot products, the three
// stage Gram multipliers and the determinant; the queue and the back end
// follow, the back end built around the two 161-stage pipelined dividers.
// Reset clears only the valid bits and the queue pointers and count.
// The front end and the back end stall separately; the two-entry queue
// absorbs the difference. While the output register holds a result the back
// end stalls, and the front end takes items in until it and the queue are full.
// ----------------------------------------------------------------------------
module triangle_barycentric_weights_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tbw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tbw_pkg::out_item_t out_item_o
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  tbw_pkg::gram_t push_item, pop_item;

  tbw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  tbw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  tbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
